// ----- design/sha512_pkg.sv -----
// Package with the SHA-512 constants, round function helpers and shared types.
package sha512_pkg;

  localparam int WordW = 64;

  typedef logic [WordW-1:0] word_t;

  localparam word_t PadMarker = 64'h8000_0000_0000_0000;
  localparam logic [3:0] LenSlot = 4'd15;
  localparam logic [3:0] PadEndSlot = 4'd14;
  localparam logic [6:0] LastRound = 7'd79;

  typedef word_t hash_t [8];

  localparam hash_t InitHash = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b,
    64'h3c6ef372fe94f82b, 64'ha54ff53a5f1d36f1,
    64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179
  };

  function automatic word_t round_k(input logic [6:0] idx);
    word_t k;
    unique case (idx)
      7'd0: k = 64'h428a2f98d728ae22;  7'd1: k = 64'h7137449123ef65cd;
      7'd2: k = 64'hb5c0fbcfec4d3b2f;  7'd3: k = 64'he9b5dba58189dbbc;
      7'd4: k = 64'h3956c25bf348b538;  7'd5: k = 64'h59f111f1b605d019;
      7'd6: k = 64'h923f82a4af194f9b;  7'd7: k = 64'hab1c5ed5da6d8118;
      7'd8: k = 64'hd807aa98a3030242;  7'd9: k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c; 7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f; 7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235; 7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2; 7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5; 7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275; 7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4; 7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab; 7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f; 7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2; 7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f; 7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc; 7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed; 7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de; 7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6; 7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364; 7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791; 7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218; 7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a; 7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8; 7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99; 7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63; 7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373; 7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc; 7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72; 7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28; 7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915; 7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c; 7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e; 7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba; 7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae; 7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84; 7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc; 7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6; 7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec; 7'd79: k = 64'h6c44198c4a475817;
      default: k = '0;
    endcase
    return k;
  endfunction

  function automatic word_t rotr(input word_t v, input int s);
    return (v >> s) | (v << (WordW - s));
  endfunction

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } rnd_ctrl_t;

endpackage

// ----- design/sha512_if.sv -----
// Valid/ready channel interfaces for the message and digest streams.
interface sha512_in_if;
  import sha512_pkg::*;
  logic       valid;
  logic       ready;
  word_t      message_word;
  logic [3:0] byte_count;
  logic       final_req;
  modport source (output valid, message_word, byte_count, final_req, input ready);
  modport sink (input valid, message_word, byte_count, final_req, output ready);
endinterface

interface sha512_out_if;
  import sha512_pkg::*;
  logic       valid;
  logic       ready;
  word_t      digest_word;
  logic [2:0] word_index;
  logic       last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- design/sha512_rounds.sv -----
// Compression core: one SHA-512 round per cycle over a 16-word schedule window.
module sha512_rounds
  import sha512_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  rnd_ctrl_t ctrl_in,
  input  logic      load_en,
  input  logic [3:0] load_slot,
  input  word_t     load_word,
  input  logic      chain_init,
  output logic      done,
  output word_t     chain_out [8]
);

  word_t      win_r [16];
  word_t      v_r [8];
  word_t      h_r [8];
  logic [6:0] rnd_r;
  logic       busy_r;
  logic       done_r;

  word_t w15, w2, w7, w0, w_cur, sg0, sg1, big1, big0, choose, major, t1, t2;
  logic [3:0] slot;

  always_comb begin
    slot = rnd_r[3:0];
    w15 = win_r[4'(slot + 4'd1)];
    w2 = win_r[4'(slot + 4'd14)];
    w7 = win_r[4'(slot + 4'd9)];
    w0 = win_r[slot];
    sg0 = rotr(w15, 1) ^ rotr(w15, 8) ^ (w15 >> 7);
    sg1 = rotr(w2, 19) ^ rotr(w2, 61) ^ (w2 >> 6);
    w_cur = (rnd_r < 7'd16) ? w0 : w0 + sg0 + w7 + sg1;
    big1 = rotr(v_r[4], 14) ^ rotr(v_r[4], 18) ^ rotr(v_r[4], 41);
    choose = (v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]);
    t1 = v_r[7] + big1 + choose + round_k(rnd_r) + w_cur;
    big0 = rotr(v_r[0], 28) ^ rotr(v_r[0], 34) ^ rotr(v_r[0], 39);
    major = (v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]);
    t2 = big0 + major;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rnd_r <= '0;
      h_r <= InitHash;
    end else begin
      done_r <= 1'b0;
      if (chain_init) begin
        h_r <= InitHash;
      end
      if (load_en) begin
        win_r[load_slot] <= load_word;
      end
      if (ctrl_in.start) begin
        busy_r <= 1'b1;
        rnd_r <= '0;
        v_r <= h_r;
      end else if (busy_r) begin
        win_r[slot] <= w_cur;
        v_r[7] <= v_r[6];
        v_r[6] <= v_r[5];
        v_r[5] <= v_r[4];
        v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2];
        v_r[2] <= v_r[1];
        v_r[1] <= v_r[0];
        v_r[0] <= t1 + t2;
        if (rnd_r == LastRound) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
          rnd_r <= '0;
          for (int i = 0; i < 8; i++) begin
            h_r[i] <= h_r[i] + ((i == 0) ? t1 + t2 : (i == 4) ? v_r[3] + t1 : v_r[3'(i-1)]);
          end
        end else begin
          rnd_r <= rnd_r + 7'd1;
        end
      end
    end
  end

  assign done = done_r;
  assign chain_out = h_r;

  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> rnd_r <= LastRound) else $error("round counter out of range");
  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r) && !busy_r && ctrl_in.done)
    else $error("done without finished rounds");
  a_idle_counter: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> rnd_r == '0) else $error("round counter not cleared when idle");
  a_busy_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> ctrl_in.busy) else $error("rounds running outside the run phase");

endmodule

// ----- design/sha512_hash_engine_unit.sv -----
// Top level of the SHA-512 hash engine: input sequencer, padding and digest output.
// Message words are taken one per cycle while the engine is idle; a word that completes
// a 128-byte block starts 80 rounds at one round per cycle in the round unit, during
// which no word is accepted. A final word adds padding words, one per cycle, and
// possibly a second block, then the eight digest words are presented one per cycle
// as the sink takes them.
module sha512_hash_engine_unit
  import sha512_pkg::*;
(
  input logic clk,
  input logic rst_n,
  sha512_in_if.sink    in_ch,
  sha512_out_if.source out_ch
);

  typedef enum logic [2:0] {S_IDLE, S_PAD, S_RUN, S_OUT} state_t;

  state_t     state_r;
  logic [3:0] cnt_r;
  word_t      len_r;
  logic       fin_r;
  logic       pad_zero_r;
  logic       len_room_r;
  logic       len_blk_r;
  logic [2:0] oidx_r;
  logic       chain_init;
  logic       start_r;

  rnd_ctrl_t  ctrl;
  logic       done;
  word_t      chain [8];

  logic       load_en;
  word_t      load_word;
  logic [3:0] nb;
  word_t      keep, fword;
  logic       acc;

  assign in_ch.ready = (state_r == S_IDLE);
  assign acc = in_ch.valid && in_ch.ready;

  always_comb begin
    nb = (in_ch.byte_count > 4'd8) ? 4'd8 : in_ch.byte_count;
    keep = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < nb) begin
        keep[63-8*i -: 8] = 8'hff;
      end
    end
    fword = (in_ch.message_word & keep);
    if (nb != 4'd8) begin
      fword[63 - 8*nb -: 8] = 8'h80;
    end
  end

  always_comb begin
    load_en = 1'b0;
    load_word = '0;
    if (acc) begin
      load_en = 1'b1;
      load_word = (in_ch.final_req && nb != 4'd8) ? fword : in_ch.message_word;
    end else if (state_r == S_PAD) begin
      load_en = 1'b1;
      if (!pad_zero_r) begin
        load_word = PadMarker;
      end else if (cnt_r == LenSlot && len_room_r) begin
        load_word = len_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      len_r <= '0;
      fin_r <= 1'b0;
      pad_zero_r <= 1'b0;
      len_room_r <= 1'b0;
      oidx_r <= '0;
      start_r <= 1'b0;
      chain_init <= 1'b0;
    end else begin
      start_r <= 1'b0;
      chain_init <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (acc) begin
            cnt_r <= cnt_r + 4'd1;
            if (!in_ch.final_req) begin
              len_r <= len_r + 64'd64;
              if (cnt_r == LenSlot) begin
                start_r <= 1'b1;
                state_r <= S_RUN;
              end
            end else begin
              len_r <= len_r + {57'd0, nb, 3'd0};
              fin_r <= 1'b1;
              pad_zero_r <= (nb != 4'd8);
              len_room_r <= (cnt_r != PadEndSlot);
              if (cnt_r == LenSlot) begin
                start_r <= 1'b1;
                state_r <= S_RUN;
              end else begin
                state_r <= S_PAD;
              end
            end
          end
        end
        S_PAD: begin
          cnt_r <= cnt_r + 4'd1;
          pad_zero_r <= 1'b1;
          if (!pad_zero_r) begin
            len_room_r <= (cnt_r != PadEndSlot);
          end else if (cnt_r == LenSlot) begin
            len_room_r <= 1'b1;
          end
          if (cnt_r == LenSlot) begin
            start_r <= 1'b1;
            fin_r <= pad_zero_r && (cnt_r == LenSlot) ? 1'b1 : fin_r;
            state_r <= S_RUN;
          end
        end
        S_RUN: begin
          if (done) begin
            if (!fin_r) begin
              state_r <= S_IDLE;
            end else if (pad_zero_r && cnt_r == '0 && len_blk_r) begin
              state_r <= S_OUT;
              oidx_r <= '0;
            end else begin
              state_r <= S_PAD;
            end
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            oidx_r <= oidx_r + 3'd1;
            if (oidx_r == 3'd7) begin
              state_r <= S_IDLE;
              chain_init <= 1'b1;
              len_r <= '0;
              fin_r <= 1'b0;
              pad_zero_r <= 1'b0;
              cnt_r <= '0;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // The length block is the one whose last request was the length word itself.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_blk_r <= 1'b0;
    end else if (load_en) begin
      len_blk_r <= (state_r == S_PAD) && pad_zero_r && (cnt_r == LenSlot) && len_room_r;
    end
  end

  always_comb begin
    ctrl.start = start_r;
    ctrl.busy = (state_r == S_RUN);
    ctrl.done = done;
  end

  sha512_rounds u_rounds (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl_in   (ctrl),
    .load_en   (load_en),
    .load_slot (cnt_r),
    .load_word (load_word),
    .chain_init(chain_init),
    .done      (done),
    .chain_out (chain)
  );

  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.digest_word = chain[oidx_r];
  assign out_ch.word_index = oidx_r;
  assign out_ch.last_word = (oidx_r == 3'd7);

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> !in_ch.ready) else $error("request taken while rounds run");
  a_out_only_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> fin_r) else $error("digest shown without final word");
  a_start_full: assert property (@(posedge clk) disable iff (!rst_n)
    start_r |-> cnt_r == '0) else $error("rounds started on partial block");

endmodule
